### hdl/ntf_pkg.sv
// shared types and constants for the number to text formatter
package ntf_pkg;

  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BIN_BITS = 32;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [3:0] DEC_MAX = 4'd10;
  localparam logic [3:0] HEX_MAX = 4'd8;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  localparam logic [4:0] CHAR_WIDTH_RESET = 5'd8;
  localparam logic [4:0] CONV_LAST        = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       len_zero;
    logic       conv_done;
    logic       idx_zero;
    logic       slot_free;
  } dp_sts_t;

endpackage

### hdl/number_to_text_formatter.sv
// top level of the number to text formatter: controller plus datapath
//
//   channel  direction  handshake            payload
//   in_      in         in_valid/in_stall    kind, value, digit_count, start_column, page
//   out_     out        out_valid/out_stall  character, column, row_page, last
//   cfg_     in         cfg_we               cfg_wdata (char_width)
//
// sequence: one transaction is taken, then a dispatch state; decimal modes run
//   a double dabble conversion (skipped for unsigned with a zero count); then
//   one character per cycle while the output register drains
// the single output register sets the character rate
// reset: rst_n synchronous active low, clears state and sets char_width to 8
// stalls: out_stall holds the output register and pauses emission; in_stall
//   is high from acceptance until the last character is in the output register
module number_to_text_formatter
  import ntf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_digit_count,
  input  logic [7:0]  in_start_column,
  input  logic [2:0]  in_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic [7:0]  out_column,
  output logic [2:0]  out_row_page,
  output logic        out_last
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  ntf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // conversion registers, column accumulator and output register
  ntf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_digit_count  (in_digit_count),
    .in_start_column (in_start_column),
    .in_page         (in_page),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_character   (out_character),
    .out_column      (out_column),
    .out_row_page    (out_row_page),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

`ifndef SYNTHESIS
  // a new transaction is only taken when nothing else is in flight
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(cmd.conv_step || cmd.emit_sign || cmd.emit_digit))
    else $error("transaction accepted while work in progress");

  // an emitted character shows up on the output next cycle
  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |=> out_valid)
    else $error("emitted character not presented");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.conv_step, cmd.emit_sign, cmd.emit_digit}))
    else $error("conflicting datapath commands");

  // emission never overwrites a stalled character
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !(cmd.emit_sign || cmd.emit_digit))
    else $error("output register overwritten under stall");
`endif

endmodule

### hdl/ntf_datapath.sv
// datapath: item registers, double dabble converter, character output register
module ntf_datapath
  import ntf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_digit_count,
  input  logic [7:0]  in_start_column,
  input  logic [2:0]  in_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic [7:0]  out_column,
  output logic [2:0]  out_row_page,
  output logic        out_last,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts
);

  logic [4:0]          char_width_r;
  logic [1:0]          kind_r;
  logic                neg_r;
  logic [3:0]          len_r;
  logic [3:0]          idx_r;
  logic [4:0]          cnt_r;
  logic [BIN_BITS-1:0] bin_r;
  logic [4*DIGITS-1:0] dig_r;
  logic [7:0]          col_r;
  logic [2:0]          page_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [6:0]          out_character_r;
  logic [7:0]          out_column_r;
  logic [2:0]          out_row_page_r;
  logic                out_last_r;

  logic [3:0]          len_clamped;
  logic [31:0]         mag;
  logic [4*DIGITS-1:0] dig_adj;
  logic [3:0]          digs [DIGITS];
  logic [3:0]          digit;
  logic [3:0]          hex_off;
  logic [6:0]          digit_char;
  logic                emit;

  // digit count clamp per mode
  always_comb begin
    if (in_kind == KIND_HEX) begin
      len_clamped = (in_digit_count > HEX_MAX) ? HEX_MAX : in_digit_count;
    end else begin
      len_clamped = (in_digit_count > DEC_MAX) ? DEC_MAX : in_digit_count;
    end
  end

  assign mag = (in_kind == KIND_SDEC && in_value[31]) ? (32'd0 - in_value) : in_value;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    logic [3:0] nib;
    nib = 4'd0;
    for (int k = 0; k < DIGITS; k++) begin
      nib = dig_r[4*k +: 4];
      dig_adj[4*k +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      digs[k] = dig_r[4*k +: 4];
    end
  end

  assign digit   = digs[idx_r];
  assign hex_off = digit - 4'd10;
  assign digit_char = (digit < 4'd10) ? (CHAR_ZERO + {3'b000, digit})
                                      : (CHAR_A + {3'b000, hex_off});

  assign emit = cmd.emit_sign | cmd.emit_digit;

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_width_r <= CHAR_WIDTH_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        char_width_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      neg_r  <= in_value[31];
      len_r  <= len_clamped;
      idx_r  <= len_clamped - 4'd1;
      cnt_r  <= 5'd0;
      col_r  <= in_start_column;
      page_r <= in_page;
      if (in_kind == KIND_HEX) begin
        dig_r <= {8'h00, in_value};
        bin_r <= '0;
      end else begin
        dig_r <= '0;
        bin_r <= mag;
      end
    end else if (cmd.conv_step) begin
      {dig_r, bin_r} <= {dig_adj[4*DIGITS-2:0], bin_r, 1'b0};
      cnt_r <= cnt_r + 5'd1;
    end else if (emit) begin
      col_r <= col_r + {3'b000, char_width_r};
      if (cmd.emit_digit) begin
        idx_r <= idx_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_character_r <= cmd.emit_sign ? (neg_r ? CHAR_MINUS : CHAR_PLUS) : digit_char;
      out_column_r    <= col_r;
      out_row_page_r  <= page_r;
      out_last_r      <= cmd.emit_sign ? (len_r == 4'd0) : (idx_r == 4'd0);
    end
  end

  assign sts.kind      = kind_r;
  assign sts.len_zero  = (len_r == 4'd0);
  assign sts.conv_done = (cnt_r == CONV_LAST);
  assign sts.idx_zero  = (idx_r == 4'd0);
  assign sts.slot_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_column    = out_column_r;
  assign out_row_page  = out_row_page_r;
  assign out_last      = out_last_r;

endmodule

### hdl/ntf_ctrl.sv
// controller state machine sequencing load, conversion and character emission
module ntf_ctrl
  import ntf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        case (sts.kind)
          KIND_HEX:  state_nxt = sts.len_zero ? ST_IDLE : ST_DIGIT;
          KIND_UDEC: state_nxt = sts.len_zero ? ST_IDLE : ST_CONV;
          KIND_SDEC: state_nxt = ST_CONV;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          state_nxt = (sts.kind == KIND_SDEC) ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) state_nxt = sts.len_zero ? ST_IDLE : ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts.slot_free && sts.idx_zero) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_START: ;
      ST_CONV:  cmd.conv_step  = 1'b1;
      ST_SIGN:  cmd.emit_sign  = sts.slot_free;
      ST_DIGIT: cmd.emit_digit = sts.slot_free;
      default:  ;
    endcase
  end

endmodule

### bench/tb_number_to_text_formatter.sv
// testbench for the number to text formatter: random and directed numbers checked per character
module tb_number_to_text_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import ntf_pkg::*;

  // the slowest clean run is about 260 numbers, so this is plenty
  localparam int unsigned CYCLE_LIMIT = 200000;
  // covers a conversion, dispatch and eleven characters, with margin
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned NUMBERS_PER_PHASE = 33;
  localparam int unsigned LONG_HOLD = 300;

  // one input transaction
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [3:0]  digit_count;
    logic [7:0]  start_column;
    logic [2:0]  page;
  } number_item_t;

  // one output transaction, a single character of a run
  typedef struct {
    logic [6:0] character;
    logic [7:0] column;
    logic [2:0] row_page;
    logic       last;
  } glyph_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_value = '0;
  logic [3:0]  in_digit_count = '0;
  logic [7:0]  in_start_column = '0;
  logic [2:0]  in_page = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_character;
  logic [7:0]  out_column;
  logic [2:0]  out_row_page;
  logic        out_last;

  number_item_t pending_numbers[$];  // numbers waiting to be offered
  glyph_t       expected_chars[$];   // characters predicted but not yet seen
  number_item_t next_number;
  glyph_t       seen_char;
  glyph_t       want_char;

  logic [4:0]  char_width_model;     // our copy of the column advance register
  bit          in_taken = 1'b0;      // set at the edge that accepts an input transaction
  bit          idle_on = 1'b1;       // random gaps and stalls allowed
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned long_hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  number_to_text_formatter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_digit_count  (in_digit_count),
    .in_start_column (in_start_column),
    .in_page         (in_page),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_character   (out_character),
    .out_column      (out_column),
    .out_row_page    (out_row_page),
    .out_last        (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // appends one predicted character; column advances by the register value and wraps at 256
  function automatic void add_glyph(input logic [6:0] ch, input int unsigned k,
                                    input logic [7:0] start, input logic [2:0] page);
    glyph_t      g;
    logic [31:0] offset;
    offset      = k * char_width_model;
    g.character = ch;
    g.column    = start + offset[7:0];
    g.row_page  = page;
    g.last      = 1'b0;
    expected_chars.push_back(g);
  endfunction

  // works out the character run of one accepted number
  function automatic void predict_chars(input number_item_t it);
    logic [3:0]  len;
    logic [31:0] mag;
    logic [3:0]  digs[10];
    logic [3:0]  d;
    int unsigned n;
    int unsigned first;
    first = expected_chars.size();
    n     = 0;
    len   = it.digit_count;
    mag   = it.value;
    if (it.kind == KIND_HEX) begin
      if (len > HEX_MAX) len = HEX_MAX;
      // most significant nibble of the run first
      for (int i = int'(len) - 1; i >= 0; i--) begin
        d = it.value[4*i +: 4];
        add_glyph((d < 4'd10) ? CHAR_ZERO + 7'(d) : CHAR_A + 7'(d) - 7'd10,
                  n, it.start_column, it.page);
        n++;
      end
    end else if (it.kind == KIND_UDEC || it.kind == KIND_SDEC) begin
      if (len > DEC_MAX) len = DEC_MAX;
      if (it.kind == KIND_SDEC) begin
        // sign always goes out, even with no digits; most negative value wraps to 2^31
        if (it.value[31]) mag = 32'd0 - it.value;
        add_glyph(it.value[31] ? CHAR_MINUS : CHAR_PLUS, n, it.start_column, it.page);
        n++;
      end
      // low digits only: the run keeps the value modulo 10^len
      for (int i = 0; i < int'(len); i++) begin
        digs[i] = 4'(mag % 32'd10);
        mag     = mag / 32'd10;
      end
      for (int i = int'(len) - 1; i >= 0; i--) begin
        add_glyph(CHAR_ZERO + 7'(digs[i]), n, it.start_column, it.page);
        n++;
      end
    end
    // unused kind code falls through and produces nothing
    if (expected_chars.size() > first) begin
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic number_item_t make_number(input logic [1:0] kind, input logic [31:0] value,
                                               input logic [3:0] count, input logic [7:0] col,
                                               input logic [2:0] page);
    number_item_t it;
    it.kind         = kind;
    it.value        = value;
    it.digit_count  = count;
    it.start_column = col;
    it.page         = page;
    return it;
  endfunction

  // random number biased toward the interesting values and toward well formed counts
  function automatic number_item_t random_number();
    number_item_t it;
    int unsigned  r;
    r = $urandom_range(0, 15);
    if (r == 0) it.kind = KIND_NONE;
    else if (r % 3 == 0) it.kind = KIND_UDEC;
    else if (r % 3 == 1) it.kind = KIND_SDEC;
    else it.kind = KIND_HEX;
    case ($urandom_range(0, 9))
      0:       it.value = 32'h0000_0000;
      1:       it.value = 32'hFFFF_FFFF;
      2:       it.value = 32'h8000_0000;
      3:       it.value = 32'h7FFF_FFFF;
      4:       it.value = $urandom_range(0, 999);
      5:       it.value = 32'd0 - $urandom_range(1, 999);
      default: it.value = $urandom;
    endcase
    // mostly within the clamp, sometimes anything the field holds
    if ($urandom_range(0, 3) == 0) it.digit_count = $urandom_range(0, 15);
    else it.digit_count = $urandom_range(1, 10);
    it.start_column = $urandom_range(0, 255);
    it.page         = $urandom_range(0, 7);
    return it;
  endfunction

  // input side: note the accepted transaction and predict its characters
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_chars(make_number(in_kind, in_value, in_digit_count, in_start_column, in_page));
      in_taken = 1'b1;
    end
  end

  // driver: presents the next pending number once the current one is gone,
  // with optional random gaps between transactions
  always @(negedge clk) begin
    if (in_taken || !in_valid) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_numbers.size() != 0) begin
        next_number = pending_numbers.pop_front();
        in_kind         <= next_number.kind;
        in_value        <= next_number.value;
        in_digit_count  <= next_number.digit_count;
        in_start_column <= next_number.start_column;
        in_page         <= next_number.page;
        in_valid        <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a long hold when asked, otherwise short random stall bursts
  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      long_hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    end
  end

  // monitor: every accepted character is checked field by field against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_char.character = out_character;
      seen_char.column    = out_column;
      seen_char.row_page  = out_row_page;
      seen_char.last      = out_last;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%h at column %0d",
                                  seen_char.character, seen_char.column));
      end else begin
        want_char = expected_chars.pop_front();
        if (seen_char.character !== want_char.character)
          report_mismatch($sformatf("character 0x%h, expected 0x%h",
                                    seen_char.character, want_char.character));
        if (seen_char.column !== want_char.column)
          report_mismatch($sformatf("column %0d, expected %0d",
                                    seen_char.column, want_char.column));
        if (seen_char.row_page !== want_char.row_page)
          report_mismatch($sformatf("row_page %0d, expected %0d",
                                    seen_char.row_page, want_char.row_page));
        if (seen_char.last !== want_char.last)
          report_mismatch($sformatf("last %b, expected %b",
                                    seen_char.last, want_char.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // waits until every number is accepted and every character seen, then lets
  // the block finish any run that produces no characters
  task automatic drain_block();
    while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // column advance register write, only while the block is idle
  task automatic write_char_width(input logic [4:0] w);
    @(negedge clk);
    cfg_wdata = w;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    char_width_model = w;
  endtask

  // phase widths cover zero, all ones, the legal extremes and out of range values
  logic [4:0] phase_width[7];

  initial begin
    phase_width = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd3, 5'd8};
    phase_width[6] = $urandom_range(2, 15);
    char_width_model = CHAR_WIDTH_RESET;

    // reset held, then released on a falling edge
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed numbers at the reset width
    // unsigned: extremes, truncation to the low digits, zero count, clamped count
    pending_numbers.push_back(make_number(KIND_UDEC, 32'h0000_0000, 4'd10, 8'd0, 3'd0));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'hFFFF_FFFF, 4'd10, 8'd255, 3'd7));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'd1234567890, 4'd4, 8'd10, 3'd1));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'd42, 4'd0, 8'd20, 3'd2));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'd987654321, 4'd15, 8'd250, 3'd3));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'd7, 4'd1, 8'd128, 3'd4));
    // signed: most negative, most positive, small negative, sign alone, clamped count
    pending_numbers.push_back(make_number(KIND_SDEC, 32'h8000_0000, 4'd10, 8'd0, 3'd5));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'h7FFF_FFFF, 4'd10, 8'd200, 3'd6));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'hFFFF_FFFF, 4'd3, 8'd64, 3'd7));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'hFFFF_FF85, 4'd0, 8'd33, 3'd0));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'd0, 4'd0, 8'd255, 3'd1));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'd305419896, 4'd12, 8'd240, 3'd2));
    // hex: every digit letter, clamped count, zero count, single nibble
    pending_numbers.push_back(make_number(KIND_HEX, 32'hDEAD_BEEF, 4'd8, 8'd0, 3'd3));
    pending_numbers.push_back(make_number(KIND_HEX, 32'h0123_ABCF, 4'd15, 8'd250, 3'd4));
    pending_numbers.push_back(make_number(KIND_HEX, 32'h89AB_CDEF, 4'd9, 8'd100, 3'd5));
    pending_numbers.push_back(make_number(KIND_HEX, 32'h1234_5678, 4'd0, 8'd5, 3'd6));
    pending_numbers.push_back(make_number(KIND_HEX, 32'hFFFF_FFFF, 4'd1, 8'd255, 3'd7));
    pending_numbers.push_back(make_number(KIND_HEX, 32'h0000_0000, 4'd8, 8'd77, 3'd0));
    // unused kind code: ignored, and must not disturb the following number
    pending_numbers.push_back(make_number(KIND_NONE, 32'hFFFF_FFFF, 4'd15, 8'd255, 3'd7));
    pending_numbers.push_back(make_number(KIND_UDEC, 32'd55, 4'd2, 8'd1, 3'd1));
    pending_numbers.push_back(make_number(KIND_NONE, 32'd0, 4'd0, 8'd0, 3'd0));
    pending_numbers.push_back(make_number(KIND_SDEC, 32'hFFFF_FFFE, 4'd1, 8'd2, 3'd2));
    drain_block();

    // random phases, one column advance each
    for (int p = 0; p < 7; p++) begin
      write_char_width(phase_width[p]);
      // one phase holds the output off for a long stretch so the block backs up
      if (p == 2) long_hold_cycles = LONG_HOLD;
      // the last phase runs at full rate on both sides
      if (p == 6) idle_on = 1'b0;
      for (int i = 0; i < NUMBERS_PER_PHASE; i++) pending_numbers.push_back(random_number());
      drain_block();
    end

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
